@@ src/qmr_pkg.sv @@
// Shared types and constants of the bounded queue with match removal.
package qmr_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int DATA_W         = 32;
   localparam int CAP_W          = 5;
   localparam int OCC_W          = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      op_type            cmd;
      logic [DATA_W-1:0] data;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] word;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;         // one-cycle command on the accepted item
      logic scan_start;   // capture key and match vector
      logic scan_step;    // advance the search by one entry
      logic scan_finish;  // close the search and load the result
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;     // result register empty or draining
      logic scan_hit;     // entry at the search position matches
      logic scan_end;     // search position reached the count
   } dp_status_type;

endpackage

@@ src/qmr_ctrl.sv @@
// Controller state machine: input handshake and match search sequencing.
module qmr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  qmr_pkg::op_type       req_op,
   input  qmr_pkg::dp_status_type dp_status,
   output logic                  req_stall,
   output qmr_pkg::ctl_type      ctl
);
   import qmr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      scan_done;

   assign req_stall = !((state_ff == S_IDLE) && dp_status.out_free);
   assign accept    = req_valid && !req_stall;
   assign scan_done = dp_status.scan_hit || dp_status.scan_end;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_REMOVE)) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_done && dp_status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.exec       = accept && (req_op != OP_REMOVE);
            ctl.scan_start = accept && (req_op == OP_REMOVE);
         end
         S_SCAN: begin
            ctl.scan_step   = !scan_done;
            ctl.scan_finish = scan_done && dp_status.out_free;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> req_stall)
      else $error("input taken during match search");

   a_remove_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_REMOVE)) |=> (state_ff == S_SCAN))
      else $error("remove did not start a search");

endmodule

@@ src/qmr_dp.sv @@
// Datapath: entry cells, count, capacity, match vector and result register.
module qmr_dp #(
   parameter int DEPTH      = qmr_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = qmr_pkg::WORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qmr_pkg::req_type             req_item,
   input  qmr_pkg::ctl_type             ctl,
   input  logic                         csr_write,
   input  logic [qmr_pkg::CAP_W-1:0]    csr_data,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output qmr_pkg::rsp_type             rsp_item,
   output qmr_pkg::dp_status_type       dp_status
);
   import qmr_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [WORD_WIDTH-1:0] cells_ff [DEPTH];
   logic [WORD_WIDTH-1:0] cells_in [DEPTH];
   logic [CW-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]      capacity_ff;
   logic [WORD_WIDTH-1:0] key_ff;
   logic [DEPTH-1:0]      mvec_ff, mvec_in;
   logic [CW-1:0]         pos_ff, pos_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  rsp_load;
   logic                  push_en;
   logic                  shift_en;
   logic [CW-1:0]         shift_pos;
   logic                  push_ok;
   logic [WORD_WIDTH-1:0] req_word;

   assign req_word = WORD_WIDTH'(req_item.data);
   assign push_ok  = (CMPW'(count_ff) < CMPW'(capacity_ff)) && (count_ff < DEPTH_C);

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;
   assign dp_status.scan_hit = mvec_ff[0];
   assign dp_status.scan_end = (pos_ff == count_ff);

   // command decode and result formation
   always_comb begin
      count_in  = count_ff;
      rsp_load  = 1'b0;
      rsp_in    = '0;
      push_en   = 1'b0;
      shift_en  = 1'b0;
      shift_pos = '0;
      if (ctl.exec) begin
         rsp_load = 1'b1;
         unique case (req_item.cmd) inside
            OP_PUSH: begin
               if (push_ok) begin
                  push_en       = 1'b1;
                  count_in      = count_ff + CW'(1);
                  rsp_in.status = ST_OK;
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_PEEK, OP_POP: begin
               if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.status = ST_OK;
                  rsp_in.word   = DATA_W'(cells_ff[0]);
                  if (req_item.cmd == OP_POP) begin
                     shift_en = 1'b1;
                     count_in = count_ff - CW'(1);
                  end
               end
            end
            default: rsp_in.status = ST_NOMATCH;
         endcase
      end else if (ctl.scan_finish) begin
         rsp_load = 1'b1;
         if (mvec_ff[0]) begin
            rsp_in.status = ST_OK;
            rsp_in.word   = DATA_W'(key_ff);
            shift_en      = 1'b1;
            shift_pos     = pos_ff;
            count_in      = count_ff - CW'(1);
         end else begin
            rsp_in.status = ST_NOMATCH;
         end
      end
      rsp_in.occupancy = OCC_W'(count_in);
   end

   // each cell loads at the tail on push; all but the last take their neighbour on close-up
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g < DEPTH - 1) begin : g_mid
         always_comb begin
            cells_in[g] = cells_ff[g];
            if (push_en && (count_ff == CW'(g))) begin
               cells_in[g] = req_word;
            end else if (shift_en && (CW'(g) >= shift_pos)) begin
               cells_in[g] = cells_ff[g+1];
            end
         end
      end else begin : g_last
         always_comb begin
            cells_in[g] = cells_ff[g];
            if (push_en && (count_ff == CW'(g))) cells_in[g] = req_word;
         end
      end
      always_ff @(posedge clock) begin
         cells_ff[g] <= cells_in[g];
      end
   end

   // search: parallel compare on start, then one bit per cycle from the head
   always_comb begin
      mvec_in = mvec_ff;
      pos_in  = pos_ff;
      if (ctl.scan_start) begin
         pos_in = '0;
         for (int i = 0; i < DEPTH; i++) begin
            mvec_in[i] = (cells_ff[i] == req_word) && (CW'(i) < count_ff);
         end
      end else if (ctl.scan_step) begin
         mvec_in = mvec_ff >> 1;
         pos_in  = pos_ff + CW'(1);
      end
   end

   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else          rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) capacity_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      mvec_ff <= mvec_in;
      pos_ff  <= pos_in;
      if (ctl.scan_start) key_ff <= req_word;
      if (rsp_load)       rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("count beyond depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl.scan_step || ctl.scan_finish) |-> (pos_ff <= count_ff))
      else $error("search ran past the count");

   a_occ_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.occupancy == OCC_W'(count_ff)))
      else $error("held result occupancy differs from count");

endmodule

@@ src/bounded_queue_with_match_remove_top.sv @@
// Top level of the bounded queue with match removal.
//
// Use:
//   req_ channel: one command per transfer (push, peek, pop, remove first
//   match) with a data word, taken when req_valid is high and req_stall low.
//   rsp_ channel: exactly one result per command (status, word, occupancy),
//   taken when rsp_valid is high and rsp_stall low.
//   csr_ channel: writes the capacity; csr_ready is always high. Write it only
//   while the queue is idle.
// Timing and throughput:
//   push, peek and pop finish in the accepting cycle; results appear in the
//   next cycle and a new command is taken every cycle while results drain.
//   Remove-match compares all entries at once on acceptance, then walks the
//   match vector one entry a cycle from the head, during which no command is
//   taken. The walk sets its rate.
// Reset (synchronous): the queue empties, capacity returns to 16, no result
//   is pending. Entry contents are not cleared; only held entries are read.
// Receiver stall: the result waits in its register; one more command may be
//   accepted only as that register drains, otherwise req_stall is raised.
module bounded_queue_with_match_remove_top #(
   parameter int DEPTH      = qmr_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = qmr_pkg::WORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  qmr_pkg::req_type          req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output qmr_pkg::rsp_type          rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [qmr_pkg::CAP_W-1:0] csr_data
);
   import qmr_pkg::*;

   ctl_type       ctl;
   dp_status_type dp_status;

   // capacity register accepts a transfer on any cycle
   assign csr_ready = 1'b1;

   qmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_item.cmd),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   qmr_dp #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .dp_status (dp_status)
   );

endmodule
